FILE: hdl/tabulated_inverse_lookup_core_defines.svh
// ----------------------------------------------------------------------------
// tabulated inverse lookup core defines
// assertion macros shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef TABULATED_INVERSE_LOOKUP_CORE_DEFINES_SVH
`define TABULATED_INVERSE_LOOKUP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TIL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("%m: check failed");
`define TIL_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("%m: check failed");
`else
`define TIL_ASSERT(lbl, prop)
`define TIL_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/til_pkg.sv
// ----------------------------------------------------------------------------
// til_pkg
// types and constants of the tabulated inverse lookup core
// ----------------------------------------------------------------------------
`default_nettype none

package til_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam int ARG_W     = 32;
   localparam int VAL_W     = 32;
   localparam int CFG_W     = 11;
   localparam int IDX_W     = 10;
   localparam int ENTRY_W   = 4 * ARG_W;
   localparam int FRAC_W    = 16;
   localparam int CURV_SHIFT = 15;

   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int TRUNC_W   = 53;
   localparam int YE_W      = 52;
   localparam int XS_W      = 53;

   localparam int DVD_W     = 66;
   localparam int DVS_W     = 32;
   localparam int DIV_STEPS = DVD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int SQ_IN_W   = 64;
   localparam int SQ_OUT_W  = 32;
   localparam int SQ_REM_W  = 33;
   localparam int SQ_STEPS  = SQ_OUT_W;
   localparam int SQ_CNT_W  = $clog2(SQ_STEPS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_ENTRIES = 1'b0;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_PROBE, S_STEP, S_RD_B, S_GOT_B, S_DECIDE, S_GOT_A,
      S_LMUL, S_LDIV, S_LWAIT, S_LFIN, S_QCHK, S_TMUL1, S_TMUL2, S_TSUB,
      S_SQRT, S_SWAIT, S_TDIV, S_TWAIT, S_TFIN, S_QOUT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_QSTART, OP_PROBE, OP_STEP, OP_RD_B, OP_GOT_B,
      OP_RD_A, OP_GOT_A, OP_LMUL, OP_LDIV, OP_LFIN, OP_TMUL1, OP_TMUL2,
      OP_TSUB, OP_SQRT, OP_TDIV, OP_TFIN
   } dp_op_type;

   typedef enum logic [2:0] {
      EM_NONE, EM_ZERO, EM_XB, EM_DEG, EM_LIN, EM_LIN_ST, EM_QUAD
   } emit_type;

   typedef struct packed {
      dp_op_type op;
      emit_type  emit;
      logic      sel_b;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
      logic y_zero;
      logic direct;
      logic den_zero;
      logic quad;
      logic curv_zero;
      logic div_done;
      logic sqrt_done;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: hdl/tabulated_inverse_lookup_core.sv
// load word: result strobe in the cycle after start, next word accepted at once
// query word: up to log2(entries)+1 probes, each through S_PROBE and S_STEP; strobe
// after the search for a zero query, end of table, exact hit or entry 0, after the
// divider with linear interpolation, and after root and divider for both neighbours with
// quadratic inversion; busy drops in the strobe cycle, so the next word can go in then
// synchronous reset clears the sequencer and sets entries_in_use to 1; table not cleared
// ----------------------------------------------------------------------------
// tabulated_inverse_lookup_core
// inverse table lookup with binary search and linear or quadratic interpolation
// ----------------------------------------------------------------------------
`default_nettype none

module tabulated_inverse_lookup_core #(
   parameter int TABLE_DEPTH = til_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_action,
   input  logic [til_pkg::IDX_W-1:0]           req_entry_index,
   input  logic signed [til_pkg::ARG_W-1:0]    req_entry_argument,
   input  logic [til_pkg::VAL_W-1:0]           req_entry_value,
   input  logic signed [til_pkg::ARG_W-1:0]    req_entry_slope,
   input  logic signed [til_pkg::ARG_W-1:0]    req_entry_curvature,
   input  logic [til_pkg::VAL_W-1:0]           req_query_value,
   input  logic                                req_use_quadratic,
   output logic                                rsp_valid,
   output logic signed [til_pkg::ARG_W-1:0]    rsp_result_argument,
   output logic                                rsp_status,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [til_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [til_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [til_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import til_pkg::*;

   logic [CFG_W-1:0] entries_ff;
   logic             csr_wr;
   dp_cmd_type       cmd;
   dp_stat_type      stat;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == CSR_IDX_ENTRIES);

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= CFG_W'(1);
      end else if (csr_wr) begin
         entries_ff <= pwdata[CFG_W-1:0];
      end
   end

   assign prdata = (paddr[2] == CSR_IDX_ENTRIES) ? CSR_DATA_W'(entries_ff) : '0;

   til_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .action (req_action),
      .stat   (stat),
      .cmd    (cmd),
      .busy   (busy)
   );

   til_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .entries_in_use      (entries_ff),
      .req_entry_index     (req_entry_index),
      .req_entry_argument  (req_entry_argument),
      .req_entry_value     (req_entry_value),
      .req_entry_slope     (req_entry_slope),
      .req_entry_curvature (req_entry_curvature),
      .req_query_value     (req_query_value),
      .req_use_quadratic   (req_use_quadratic),
      .rsp_valid           (rsp_valid),
      .rsp_result_argument (rsp_result_argument),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire

FILE: hdl/til_div.sv
// ----------------------------------------------------------------------------
// til_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module til_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [til_pkg::DVD_W-1:0]    dividend,
   input  logic [til_pkg::DVS_W-1:0]    divisor,
   output logic                         busy,
   output logic                         done,
   output logic [til_pkg::DVD_W-1:0]    quotient
);
   import til_pkg::*;

   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       diff;
   logic                 ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      ge      = !diff[DVS_W];
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/til_sqrt.sv
// ----------------------------------------------------------------------------
// til_sqrt
// digit by digit integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module til_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [til_pkg::SQ_IN_W-1:0]   radicand,
   output logic                          busy,
   output logic                          done,
   output logic [til_pkg::SQ_OUT_W-1:0]  root
);
   import til_pkg::*;

   logic [SQ_IN_W-1:0]  src_ff, src_in;
   logic [SQ_REM_W-1:0] rem_ff, rem_in;
   logic [SQ_OUT_W-1:0] root_ff, root_in;
   logic [SQ_CNT_W-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [SQ_REM_W+1:0] remsh;
   logic [SQ_REM_W+1:0] trial;
   logic [SQ_REM_W+1:0] diff;
   logic                ge;

   always_comb begin
      remsh   = {rem_ff, src_ff[SQ_IN_W-1:SQ_IN_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = remsh - trial;
      ge      = !diff[SQ_REM_W+1];
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         src_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[SQ_REM_W-1:0] : remsh[SQ_REM_W-1:0];
         root_in = {root_ff[SQ_OUT_W-2:0], ge};
         src_in  = {src_ff[SQ_IN_W-3:0], 2'b00};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == SQ_CNT_W'(SQ_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

FILE: hdl/til_dp.sv
// ----------------------------------------------------------------------------
// til_dp
// datapath: entry memory, search registers, multiplier, divider, square root
// ----------------------------------------------------------------------------
`default_nettype none

module til_dp #(
   parameter int TABLE_DEPTH = til_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  til_pkg::dp_cmd_type                cmd,
   output til_pkg::dp_stat_type               stat,
   input  logic [til_pkg::CFG_W-1:0]          entries_in_use,
   input  logic [til_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [til_pkg::ARG_W-1:0]   req_entry_argument,
   input  logic [til_pkg::VAL_W-1:0]          req_entry_value,
   input  logic signed [til_pkg::ARG_W-1:0]   req_entry_slope,
   input  logic signed [til_pkg::ARG_W-1:0]   req_entry_curvature,
   input  logic [til_pkg::VAL_W-1:0]          req_query_value,
   input  logic                               req_use_quadratic,
   output logic                               rsp_valid,
   output logic signed [til_pkg::ARG_W-1:0]   rsp_result_argument,
   output logic                               rsp_status
);
   import til_pkg::*;

   `include "tabulated_inverse_lookup_core_defines.svh"

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int NW = $clog2(TABLE_DEPTH + 1);
   localparam logic [XS_W-1:0] SAT_HI = {{(XS_W-ARG_W){1'b0}}, 1'b0, {(ARG_W-1){1'b1}}};
   localparam logic [XS_W-1:0] SAT_LO = {{(XS_W-ARG_W){1'b1}}, 1'b1, {(ARG_W-1){1'b0}}};

   // entry memory, {argument, value, slope, curvature}
   logic [ENTRY_W-1:0] table_mem_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic [ENTRY_W-1:0] wdata;
   logic [AW-1:0]      rd_addr;
   logic               mem_wr;
   logic               mem_rd;
   logic [31:0]        idx_ext;
   logic [31:0]        cfg_ext;
   logic [31:0]        n_calc;

   logic [VAL_W-1:0] y_ff;
   logic             quad_ff;
   logic [NW-1:0]    n_ff, lo_ff, hi_ff;
   logic [NW-1:0]    mid;
   logic [NW-1:0]    n_m1, lo_m1;
   logic             past;

   logic [ARG_W-1:0] xa_ff, va_ff, sa_ff, ca_ff;
   logic [ARG_W-1:0] xb_ff, vb_ff, sb_ff, cb_ff;
   logic [ARG_W-1:0] lin_ff;
   logic [ARG_W-1:0] den;
   logic [ARG_W:0]   dx, mag;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] pshift;
   logic [TRUNC_W-1:0]       t_ff;
   logic signed [PROD_W-1:0] dsub;
   logic [SQ_IN_W-1:0]       d_ff;

   logic [ARG_W-1:0] ve, se, ce;
   logic [ARG_W:0]   dv;
   logic [MUL_W-1:0] rdiff;
   logic [MUL_W+FRAC_W-1:0] num, nummag;
   logic [DVS_W-1:0] cmag;
   logic             neg_ff;
   logic [YE_W-1:0]  ya_ff, yb_ff, ye;

   logic [XS_W-1:0] ysum, xsum, xsat;

   logic             div_start, div_busy, div_done;
   logic [DVD_W-1:0] div_dvd, div_q;
   logic [DVS_W-1:0] div_dvs;
   logic             sq_start, sq_busy, sq_done;
   logic [SQ_OUT_W-1:0] sq_root;

   logic             rsp_valid_ff;
   logic [ARG_W-1:0] rsp_arg_ff;
   logic             rsp_st_ff;

   // addressing and search
   always_comb begin
      idx_ext = 32'(req_entry_index);
      cfg_ext = 32'(entries_in_use);
      if (cfg_ext == 32'd0) begin
         n_calc = 32'd1;
      end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
         n_calc = 32'(TABLE_DEPTH);
      end else begin
         n_calc = cfg_ext;
      end
      mid   = lo_ff + ((hi_ff - lo_ff) >> 1);
      n_m1  = n_ff - 1'b1;
      lo_m1 = lo_ff - 1'b1;
      past  = lo_ff >= n_ff;
      wdata = {req_entry_argument, req_entry_value, req_entry_slope, req_entry_curvature};
      mem_wr = (cmd.op == OP_LOAD) && (idx_ext < 32'(TABLE_DEPTH));
      mem_rd = 1'b1;
      case (cmd.op)
         OP_PROBE: rd_addr = mid[AW-1:0];
         OP_RD_B:  rd_addr = past ? n_m1[AW-1:0] : lo_ff[AW-1:0];
         OP_RD_A:  rd_addr = lo_m1[AW-1:0];
         default: begin
            rd_addr = mid[AW-1:0];
            mem_rd  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         table_mem_ff[idx_ext[AW-1:0]] <= wdata;
      end
      if (mem_rd) begin
         rd_ff <= table_mem_ff[rd_addr];
      end
   end

   // arithmetic operands
   always_comb begin
      den  = vb_ff - va_ff;
      dx   = {xb_ff[ARG_W-1], xb_ff} - {xa_ff[ARG_W-1], xa_ff};
      mag  = dx[ARG_W] ? (~dx + 1'b1) : dx;
      ve   = cmd.sel_b ? vb_ff : va_ff;
      se   = cmd.sel_b ? sb_ff : sa_ff;
      ce   = cmd.sel_b ? cb_ff : ca_ff;
      dv   = {1'b0, ve} - {1'b0, y_ff};
      case (cmd.op)
         OP_LMUL: begin
            mul_a = {2'b00, y_ff - va_ff};
            mul_b = {1'b0, mag};
         end
         OP_TMUL1: begin
            mul_a = {{2{ce[ARG_W-1]}}, ce};
            mul_b = {dv[ARG_W], dv};
         end
         default: begin
            mul_a = {{2{se[ARG_W-1]}}, se};
            mul_b = {{2{se[ARG_W-1]}}, se};
         end
      endcase
      pshift = prod_ff >>> CURV_SHIFT;
      dsub   = prod_ff - {{(PROD_W-TRUNC_W){t_ff[TRUNC_W-1]}}, t_ff};
      rdiff  = {2'b00, sq_root} - {{2{se[ARG_W-1]}}, se};
      num    = {rdiff, {FRAC_W{1'b0}}};
      nummag = rdiff[MUL_W-1] ? (~num + 1'b1) : num;
      cmag   = ce[ARG_W-1] ? (~ce + 1'b1) : ce;
      ye     = neg_ff ? (~div_q[YE_W-1:0] + 1'b1) : div_q[YE_W-1:0];
      ysum   = {ya_ff[YE_W-1], ya_ff} + {yb_ff[YE_W-1], yb_ff};
      if (!ysum[XS_W-1] && (ysum != '0)) begin
         xsum = {{(XS_W-ARG_W){xb_ff[ARG_W-1]}}, xb_ff} + {yb_ff[YE_W-1], yb_ff};
      end else begin
         xsum = {{(XS_W-ARG_W){xa_ff[ARG_W-1]}}, xa_ff} + {ya_ff[YE_W-1], ya_ff};
      end
      if ($signed(xsum) > $signed(SAT_HI)) begin
         xsat = SAT_HI;
      end else if ($signed(xsum) < $signed(SAT_LO)) begin
         xsat = SAT_LO;
      end else begin
         xsat = xsum;
      end
      div_start = (cmd.op == OP_LDIV) || (cmd.op == OP_TDIV);
      if (cmd.op == OP_LDIV) begin
         div_dvd = prod_ff[DVD_W-1:0] + DVD_W'(den >> 1);
         div_dvs = den;
      end else begin
         div_dvd = DVD_W'(nummag);
         div_dvs = cmag;
      end
      sq_start = cmd.op == OP_SQRT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff  <= NW'(1);
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         case (cmd.op)
            OP_QSTART: begin
               n_ff  <= n_calc[NW-1:0];
               lo_ff <= '0;
               hi_ff <= n_calc[NW-1:0];
            end
            OP_STEP: begin
               if (rd_ff[3*ARG_W-1:2*ARG_W] < y_ff) begin
                  lo_ff <= mid + 1'b1;
               end else begin
                  hi_ff <= mid;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_QSTART: begin
            y_ff    <= req_query_value;
            quad_ff <= req_use_quadratic;
         end
         OP_GOT_B: begin
            {xb_ff, vb_ff, sb_ff, cb_ff} <= rd_ff;
         end
         OP_GOT_A: begin
            {xa_ff, va_ff, sa_ff, ca_ff} <= rd_ff;
         end
         OP_LMUL, OP_TMUL1: begin
            prod_ff <= mul_a * mul_b;
         end
         OP_TMUL2: begin
            prod_ff <= mul_a * mul_b;
            t_ff    <= pshift[TRUNC_W-1:0]
                       + TRUNC_W'(prod_ff[PROD_W-1] && (prod_ff[CURV_SHIFT-1:0] != '0));
         end
         OP_TSUB: begin
            d_ff <= dsub[PROD_W-1] ? '0 : dsub[SQ_IN_W-1:0];
         end
         OP_LFIN: begin
            lin_ff <= dx[ARG_W] ? (xa_ff - div_q[ARG_W-1:0]) : (xa_ff + div_q[ARG_W-1:0]);
         end
         OP_TDIV: begin
            neg_ff <= rdiff[MUL_W-1] ^ ce[ARG_W-1];
         end
         OP_TFIN: begin
            if (cmd.sel_b) begin
               yb_ff <= ye;
            end else begin
               ya_ff <= ye;
            end
         end
         default: begin
         end
      endcase
   end

   til_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   til_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (d_ff),
      .busy     (sq_busy),
      .done     (sq_done),
      .root     (sq_root)
   );

   // result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit != EM_NONE;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.emit)
         EM_XB: begin
            rsp_arg_ff <= xb_ff;
            rsp_st_ff  <= 1'b0;
         end
         EM_DEG: begin
            rsp_arg_ff <= xa_ff;
            rsp_st_ff  <= 1'b1;
         end
         EM_LIN: begin
            rsp_arg_ff <= lin_ff;
            rsp_st_ff  <= 1'b0;
         end
         EM_LIN_ST: begin
            rsp_arg_ff <= lin_ff;
            rsp_st_ff  <= 1'b1;
         end
         EM_QUAD: begin
            rsp_arg_ff <= xsat[ARG_W-1:0];
            rsp_st_ff  <= 1'b0;
         end
         default: begin
            rsp_arg_ff <= '0;
            rsp_st_ff  <= 1'b0;
         end
      endcase
   end

   always_comb begin
      stat.search_done = !(lo_ff < hi_ff);
      stat.y_zero      = y_ff == '0;
      stat.direct      = past || (lo_ff == '0) || (vb_ff == y_ff);
      stat.den_zero    = den == '0;
      stat.quad        = quad_ff;
      stat.curv_zero   = (ca_ff == '0) || (cb_ff == '0);
      stat.div_done    = div_done;
      stat.sqrt_done   = sq_done;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_argument = rsp_arg_ff;
   assign rsp_status          = rsp_st_ff;

   `TIL_ASSERT(a_div_start_idle, div_start |-> !div_busy)
   `TIL_ASSERT(a_sqrt_start_idle, sq_start |-> !sq_busy)
   `TIL_ASSERT_ALWAYS(a_search_bounds, !reset |=> (lo_ff <= hi_ff) && (hi_ff <= n_ff))

endmodule

`default_nettype wire

FILE: hdl/til_ctrl.sv
// ----------------------------------------------------------------------------
// til_ctrl
// sequencer for loads, binary search, interpolation and root inversion
// ----------------------------------------------------------------------------
`default_nettype none

module til_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  action,
   input  til_pkg::dp_stat_type  stat,
   output til_pkg::dp_cmd_type   cmd,
   output logic                  busy
);
   import til_pkg::*;

   `include "tabulated_inverse_lookup_core_defines.svh"

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && (action == ACT_QUERY)) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE:  state_in = stat.search_done ? S_RD_B : S_STEP;
         S_STEP:   state_in = S_PROBE;
         S_RD_B:   state_in = S_GOT_B;
         S_GOT_B:  state_in = S_DECIDE;
         S_DECIDE: state_in = (stat.y_zero || stat.direct) ? S_IDLE : S_GOT_A;
         S_GOT_A:  state_in = S_LMUL;
         S_LMUL:   state_in = stat.den_zero ? S_IDLE : S_LDIV;
         S_LDIV:   state_in = S_LWAIT;
         S_LWAIT: begin
            if (stat.div_done) begin
               state_in = S_LFIN;
            end
         end
         S_LFIN:   state_in = S_QCHK;
         S_QCHK: begin
            sel_in = 1'b0;
            if (!stat.quad || stat.curv_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_TMUL1;
            end
         end
         S_TMUL1:  state_in = S_TMUL2;
         S_TMUL2:  state_in = S_TSUB;
         S_TSUB:   state_in = S_SQRT;
         S_SQRT:   state_in = S_SWAIT;
         S_SWAIT: begin
            if (stat.sqrt_done) begin
               state_in = S_TDIV;
            end
         end
         S_TDIV:   state_in = S_TWAIT;
         S_TWAIT: begin
            if (stat.div_done) begin
               state_in = S_TFIN;
            end
         end
         S_TFIN: begin
            if (sel_ff) begin
               state_in = S_QOUT;
            end else begin
               sel_in   = 1'b1;
               state_in = S_TMUL1;
            end
         end
         S_QOUT:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.emit  = EM_NONE;
      cmd.sel_b = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && (action == ACT_LOAD)) begin
               cmd.op   = OP_LOAD;
               cmd.emit = EM_ZERO;
            end else if (start) begin
               cmd.op = OP_QSTART;
            end
         end
         S_PROBE: begin
            if (!stat.search_done) begin
               cmd.op = OP_PROBE;
            end
         end
         S_STEP:  cmd.op = OP_STEP;
         S_RD_B:  cmd.op = OP_RD_B;
         S_GOT_B: cmd.op = OP_GOT_B;
         S_DECIDE: begin
            cmd.op = OP_RD_A;
            if (stat.y_zero) begin
               cmd.emit = EM_ZERO;
            end else if (stat.direct) begin
               cmd.emit = EM_XB;
            end
         end
         S_GOT_A: cmd.op = OP_GOT_A;
         S_LMUL: begin
            if (stat.den_zero) begin
               cmd.emit = EM_DEG;
            end else begin
               cmd.op = OP_LMUL;
            end
         end
         S_LDIV:  cmd.op = OP_LDIV;
         S_LFIN:  cmd.op = OP_LFIN;
         S_QCHK: begin
            if (!stat.quad) begin
               cmd.emit = EM_LIN;
            end else if (stat.curv_zero) begin
               cmd.emit = EM_LIN_ST;
            end
         end
         S_TMUL1: cmd.op = OP_TMUL1;
         S_TMUL2: cmd.op = OP_TMUL2;
         S_TSUB:  cmd.op = OP_TSUB;
         S_SQRT:  cmd.op = OP_SQRT;
         S_TDIV:  cmd.op = OP_TDIV;
         S_TFIN:  cmd.op = OP_TFIN;
         S_QOUT:  cmd.emit = EM_QUAD;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   `TIL_ASSERT(a_emit_ends_item, (cmd.emit != EM_NONE) |=> (state_ff == S_IDLE))
   `TIL_ASSERT(a_div_done_waited,
      stat.div_done |-> ((state_ff == S_LWAIT) || (state_ff == S_TWAIT)))
   `TIL_ASSERT(a_sqrt_done_waited, stat.sqrt_done |-> (state_ff == S_SWAIT))

endmodule

`default_nettype wire

FILE: dv/tabulated_inverse_lookup_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tabulated_inverse_lookup_core_tb
// loads tables of increasing values under several entry counts, then sends
// inverse queries in linear and quadratic mode; every result word is checked
// field by field against a predictor kept in the scoreboard
// ----------------------------------------------------------------------------
`default_nettype none

class lookup_scoreboard;
   typedef struct {
      bit [31:0] x;
      bit        st;
   } lookup_word_type;

   bit [31:0]       arg_tab[1024];
   bit [31:0]       val_tab[1024];
   bit [31:0]       slp_tab[1024];
   bit [31:0]       crv_tab[1024];
   bit [10:0]       entries_cfg = 1;
   lookup_word_type pending[$];
   int              errors = 0;
   int              loads = 0;
   int              queries = 0;
   int              quad_queries = 0;

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   function bit [31:0] int_sqrt(bit [63:0] v);
      bit [63:0] rem, root, b;
      rem = v;
      root = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (rem >= root + b) begin
            rem = rem - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root[31:0];
   endfunction

   function longint taylor_offset(int e, bit [31:0] y, inout bit ok);
      longint s, c, dv, d, r;
      s = longint'(signed'(slp_tab[e]));
      c = longint'(signed'(crv_tab[e]));
      dv = longint'({32'b0, val_tab[e]}) - longint'({32'b0, y});
      d = s * s - (c * dv) / 64'sd32768;
      if (d < 0) d = 0;
      r = longint'({32'b0, int_sqrt(d)});
      if (c == 0) begin
         ok = 0;
         return 0;
      end
      return ((r - s) * 64'sd65536) / c;
   endfunction

   function longint linear_arg(int a, int b, bit [31:0] y, inout bit st);
      longint    xa, xb, dx;
      bit [63:0] num, den, mag, q;
      bit [31:0] t;
      xa = longint'(signed'(arg_tab[a]));
      xb = longint'(signed'(arg_tab[b]));
      t = y - val_tab[a];
      num = {32'b0, t};
      t = val_tab[b] - val_tab[a];
      den = {32'b0, t};
      dx = xb - xa;
      mag = dx < 0 ? -dx : dx;
      if (den == 0) begin
         st = 1;
         return xa;
      end
      q = (num * mag + den / 2) / den;
      return dx < 0 ? xa - longint'(q) : xa + longint'(q);
   endfunction

   function void note(bit act, bit [9:0] idx, bit [31:0] ea, bit [31:0] ev,
                      bit [31:0] es, bit [31:0] ec, bit [31:0] y, bit quad);
      lookup_word_type w;
      int              n, lo, hi, mid;
      longint          x, ya, yb;
      bit              st, ok;
      st = 0;
      x = 0;
      if (act == til_pkg::ACT_LOAD) begin
         arg_tab[idx] = ea;
         val_tab[idx] = ev;
         slp_tab[idx] = es;
         crv_tab[idx] = ec;
         loads++;
      end else begin
         queries++;
         if (quad) quad_queries++;
         n = int'(entries_cfg);
         if (n == 0) n = 1;
         if (n > 1024) n = 1024;
         lo = 0;
         hi = n;
         while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (val_tab[mid] < y) lo = mid + 1;
            else hi = mid;
         end
         if (y == 0) begin
            x = 0;
         end else if (lo >= n) begin
            x = longint'(signed'(arg_tab[n - 1]));
         end else if (lo == 0 || val_tab[lo] == y) begin
            x = longint'(signed'(arg_tab[lo]));
         end else begin
            x = linear_arg(lo - 1, lo, y, st);
            if (quad && !st) begin
               ok = 1;
               ya = taylor_offset(lo - 1, y, ok);
               yb = taylor_offset(lo, y, ok);
               if (!ok) begin
                  st = 1;
               end else begin
                  x = (ya > -yb) ? longint'(signed'(arg_tab[lo])) + yb
                                 : longint'(signed'(arg_tab[lo - 1])) + ya;
                  if (x > 64'sd2147483647) x = 64'sd2147483647;
                  if (x < -64'sd2147483648) x = -64'sd2147483648;
               end
            end
         end
      end
      w.x = x[31:0];
      w.st = st;
      pending.push_back(w);
   endfunction

   task check(bit [31:0] x, bit st);
      lookup_word_type w;
      if (pending.size() == 0) begin
         report($sformatf("unexpected word x=%h st=%0d", x, st));
      end else begin
         w = pending.pop_front();
         if (x !== w.x) report($sformatf("argument %h, expected %h", x, w.x));
         if (st !== w.st) report($sformatf("status %0d, expected %0d", st, w.st));
      end
   endtask
endclass

module tabulated_inverse_lookup_core_tb;
   import til_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [CSR_ADDR_W-1:0] ENTRIES_ADDR = CSR_ADDR_W'(4 * CSR_IDX_ENTRIES);

   logic                    clock, reset, start, busy;
   logic                    req_action, req_use_quadratic;
   logic [IDX_W-1:0]        req_entry_index;
   logic signed [ARG_W-1:0] req_entry_argument, req_entry_slope, req_entry_curvature;
   logic [VAL_W-1:0]        req_entry_value, req_query_value;
   logic                    rsp_valid, rsp_status;
   logic signed [ARG_W-1:0] rsp_result_argument;
   logic                    psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata, prdata;

   lookup_scoreboard sb = new();
   bit               no_idle = 0;
   int               stall = 0;
   int               n_eff = 1;
   bit [31:0]        vals[1024];

   tabulated_inverse_lookup_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_entry_index(req_entry_index),
      .req_entry_argument(req_entry_argument), .req_entry_value(req_entry_value),
      .req_entry_slope(req_entry_slope), .req_entry_curvature(req_entry_curvature),
      .req_query_value(req_query_value), .req_use_quadratic(req_use_quadratic),
      .rsp_valid(rsp_valid), .rsp_result_argument(rsp_result_argument),
      .rsp_status(rsp_status), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note(req_action, req_entry_index, req_entry_argument, req_entry_value,
                    req_entry_slope, req_entry_curvature, req_query_value,
                    req_use_quadratic);
         if (rsp_valid) sb.check(rsp_result_argument, rsp_status);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall <= 0;
      end else if (stall >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall <= stall + 1;
      end
   end

   task send_word(bit act, bit [9:0] idx, bit [31:0] ea, bit [31:0] ev, bit [31:0] es,
                  bit [31:0] ec, bit [31:0] y, bit quad);
      if (!no_idle && $urandom_range(99) < 9) begin
         start = 0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start = 1;
      req_action = act;
      req_entry_index = idx;
      req_entry_argument = ea;
      req_entry_value = ev;
      req_entry_slope = es;
      req_entry_curvature = ec;
      req_query_value = y;
      req_use_quadratic = quad;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 0;
   endtask

   task load_entry(int i, bit [31:0] v, bit wild);
      bit [31:0] ea, es, ec;
      if (wild) begin
         ea = $urandom;
         es = $urandom;
         ec = $urandom;
      end else begin
         ea = i * 32'h0000_4000 - 32'h0100_0000 + $urandom_range(0, 32'h3fff);
         es = $urandom_range(32'h0000_4000, 32'h0040_0000);
         ec = $urandom_range(0, 3) == 0 ? 32'h0 : $urandom_range(0, 32'h0010_0000)
              - 32'h0008_0000;
      end
      send_word(ACT_LOAD, 10'(i), ea, v, es, ec, $urandom, 1'($urandom));
   endtask

   task build_table(int cnt, bit wild, bit full_span);
      bit [31:0] stp;
      stp = 32'hffff_fff0 / (cnt + 1);
      for (int i = 0; i < cnt; i++) begin
         vals[i] = (i + 1) * stp - $urandom_range(0, stp / 2);
         if (full_span && i == 0) vals[i] = 32'h0;
         if (full_span && i == cnt - 1) vals[i] = 32'hffff_ffff;
         load_entry(i, vals[i], wild);
      end
   endtask

   task write_entries(bit [10:0] v);
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel = 1;
      pwrite = 1;
      paddr = ENTRIES_ADDR;
      pwdata = CSR_DATA_W'(v);
      @(negedge clock);
      penable = 1;
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
      sb.entries_cfg = v;
      n_eff = v == 0 ? 1 : v > 1024 ? 1024 : int'(v);
   endtask

   function bit [31:0] pick_query();
      int k, j;
      k = $urandom_range(99);
      j = $urandom_range(0, n_eff - 1);
      if (k < 6) return 32'h0;
      if (k < 16) return vals[j];
      if (k < 22) return 32'hffff_ffff;
      if (k < 40) return vals[j] - $urandom_range(1, 64);
      return $urandom;
   endfunction

   task run_queries(int cnt);
      int j;
      for (int i = 0; i < cnt; i++) begin
         if ($urandom_range(99) < 8) begin
            j = $urandom_range(0, n_eff - 1);
            load_entry(j, vals[j], 1'($urandom_range(1)));
         end
         send_word(ACT_QUERY, 10'($urandom), $urandom, $urandom, $urandom, $urandom,
                   pick_query(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_action = ACT_LOAD;
      req_entry_index = 0;
      req_entry_argument = 0;
      req_entry_value = 0;
      req_entry_slope = 0;
      req_entry_curvature = 0;
      req_query_value = 0;
      req_use_quadratic = 0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = 0;
      pwdata = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset entry count, then a small table
      build_table(5, 0, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[0] + 1, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, 32'hffff_ffff, 1);
      write_entries(5);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, 32'h0, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[0], 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, 32'h1, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[2], 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[2] - 5, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[3] - 7, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, 32'hffff_ffff, 0);
      load_entry(1, vals[1], 0);
      send_word(ACT_LOAD, 2, 32'h8000_0000, vals[2], 32'h7fff_ffff, 32'h0, 0, 0);
      send_word(ACT_LOAD, 3, 32'h7fff_ffff, vals[3], 32'h8000_0000, 32'hffff_ffff, 0, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[2] - 9, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[3] - 3, 1);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[3] - 3, 0);
      send_word(ACT_QUERY, 0, 0, 0, 0, 0, vals[4] - 2, 1);

      // random phases over several entry counts
      write_entries(0);
      build_table(1, 1, 0);
      run_queries(40);
      write_entries(2);
      build_table(2, 0, 1);
      run_queries(60);
      write_entries(37);
      build_table(37, 0, 0);
      run_queries(110);
      write_entries(150);
      no_idle = 1;
      build_table(150, 1, 1);
      run_queries(60);
      no_idle = 0;
      run_queries(40);
      write_entries(9);
      build_table(9, 1, 0);
      run_queries(80);

      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run covered %0d table loads and %0d queries (%0d quadratic)",
               sb.loads, sb.queries, sb.quad_queries);
      $display("entry counts 0, 1, 2, 5, 9, 37 and 150, %0d mismatches",
               sb.errors);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

`default_nettype wire

FILE: tabulated_inverse_lookup_core.f
+incdir+hdl
hdl/til_pkg.sv
hdl/til_div.sv
hdl/til_sqrt.sv
hdl/til_dp.sv
hdl/til_ctrl.sv
hdl/tabulated_inverse_lookup_core.sv
dv/tabulated_inverse_lookup_core_tb.sv
